// File: src/csws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit-sorted worker scheduler package
// Command and status codes, sequencer states and the result type.
// ----------------------------------------------------------------------------
package csws_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned INIT_W = 8;

  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PRODUCE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_C_FRONT,
    S_SU_RD,
    S_SU_CHK,
    S_P_CHK,
    S_I_CHK,
    S_SD_RD,
    S_SD_WR,
    S_INS
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   served_id;
    logic [STAT_W-1:0] status;
    logic              wake;
  } res_t;

endpackage

// File: src/csws_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csws_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 24,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/csws_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Walks the entry memory one entry at a time to insert, remove, promote
// and demote entries.
// ----------------------------------------------------------------------------
module csws_seq #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned CREDIT_BITS = 16,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned ENT_W       = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [csws_pkg::CMD_W-1:0]   cmd_i,
  input  logic [csws_pkg::ID_W-1:0]    worker_id_i,
  input  logic [csws_pkg::INIT_W-1:0]  init_credit_i,
  output logic                         busy_o,
  output logic                         done_o,
  output csws_pkg::res_t               res_o,
  output logic                         mem_we_o,
  output logic [IDX_W-1:0]             mem_waddr_o,
  output logic [ENT_W-1:0]             mem_wdata_o,
  output logic [IDX_W-1:0]             mem_raddr_o,
  input  logic [ENT_W-1:0]             mem_rdata_i
);

  import csws_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WW    = (CREDIT_BITS > INIT_W) ? CREDIT_BITS : INIT_W;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic                   done_q, done_d;
  res_t                   res_q, res_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [IDX_W-1:0]       lo_q, lo_d;
  logic [IDX_W-1:0]       tpos_q, tpos_d;
  logic [ID_W-1:0]        id_q, id_d;
  logic [CREDIT_BITS-1:0] cred_q, cred_d;
  logic [CREDIT_BITS-1:0] prev_q, prev_d;
  logic                   rm_q, rm_d;

  logic [ID_W-1:0]        rd_id;
  logic [CREDIT_BITS-1:0] rd_cred;
  logic [CREDIT_BITS-1:0] rd_inc;
  logic [CREDIT_BITS-1:0] init_clip;
  logic [WW-1:0]          init_w;
  logic [WW-1:0]          cmax_w;
  logic [CNT_W-1:0]       ptr_inc;
  logic [CNT_W-1:0]       ptr_dec;
  logic                   full;
  logic                   id_match;
  logic                   rd_gt;
  logic                   rd_le;

  assign rd_id    = mem_rdata_i[ENT_W-1 -: ID_W];
  assign rd_cred  = mem_rdata_i[CREDIT_BITS-1:0];
  assign rd_inc   = (rd_cred == {CREDIT_BITS{1'b1}}) ? rd_cred : rd_cred + 1'b1;
  assign init_w   = WW'(init_credit_i);
  assign cmax_w   = WW'({CREDIT_BITS{1'b1}});
  assign init_clip = (init_w > cmax_w) ? CREDIT_BITS'(cmax_w) : CREDIT_BITS'(init_w);
  assign ptr_inc  = ptr_q + 1'b1;
  assign ptr_dec  = ptr_q - 1'b1;
  assign full     = (occ_q == CNT_W'(MAX_ENTRIES));
  assign id_match = (rd_id == id_q);
  assign rd_gt    = (rd_cred > cred_q);
  assign rd_le    = !rd_gt;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (cmd_i == CMD_ADD && !full && occ_q != '0) begin
            state_d = S_SD_RD;
          end else if (cmd_i == CMD_CONSUME && occ_q != '0) begin
            state_d = S_C_FRONT;
          end else if (cmd_i == CMD_PRODUCE && occ_q != '0) begin
            state_d = S_P_CHK;
          end
        end
      end
      S_C_FRONT: state_d = S_SU_RD;
      S_SU_RD: begin
        if (ptr_q == occ_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SU_CHK;
        end
      end
      S_SU_CHK: begin
        if (rm_q || rd_gt) begin
          state_d = S_SU_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_P_CHK: begin
        if (id_match) begin
          if (ptr_q != '0 && prev_q < rd_inc) begin
            state_d = S_I_CHK;
          end else begin
            state_d = S_IDLE;
          end
        end else if (ptr_inc == occ_q) begin
          state_d = S_IDLE;
        end
      end
      S_I_CHK: begin
        if (rd_le) begin
          state_d = S_SD_RD;
        end
      end
      S_SD_RD: state_d = S_SD_WR;
      S_SD_WR: begin
        if (ptr_q[IDX_W-1:0] == lo_q) begin
          state_d = S_INS;
        end else begin
          state_d = S_SD_RD;
        end
      end
      S_INS:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    occ_d       = occ_q;
    done_d      = 1'b0;
    res_d       = '0;
    ptr_d       = ptr_q;
    lo_d        = lo_q;
    tpos_d      = tpos_q;
    id_d        = id_q;
    cred_d      = cred_q;
    prev_d      = prev_q;
    rm_d        = rm_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = {id_q, cred_q};
    mem_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          id_d = worker_id_i;
          if (cmd_i == CMD_ADD) begin
            if (full) begin
              done_d       = 1'b1;
              res_d.status = STAT_FULL;
            end else if (occ_q == '0) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {worker_id_i, init_clip};
              occ_d       = occ_q + 1'b1;
              done_d      = 1'b1;
            end else begin
              cred_d = init_clip;
              lo_d   = '0;
              ptr_d  = occ_q - 1'b1;
              occ_d  = occ_q + 1'b1;
            end
          end else if (cmd_i == CMD_CONSUME) begin
            if (occ_q == '0) begin
              done_d       = 1'b1;
              res_d.status = STAT_EMPTY;
            end
          end else if (cmd_i == CMD_PRODUCE) begin
            ptr_d = '0;
            if (occ_q == '0) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {worker_id_i, CREDIT_BITS'(1)};
              occ_d       = occ_q + 1'b1;
              done_d      = 1'b1;
              res_d.wake  = 1'b1;
            end
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_C_FRONT: begin
        id_d   = rd_id;
        rm_d   = (rd_cred <= CREDIT_BITS'(1));
        cred_d = rd_cred - 1'b1;
        ptr_d  = CNT_W'(1);
      end
      S_SU_RD: begin
        mem_raddr_o = ptr_q[IDX_W-1:0];
        if (ptr_q == occ_q) begin
          done_d          = 1'b1;
          res_d.served_id = id_q;
          if (rm_q) begin
            occ_d = occ_q - 1'b1;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = ptr_dec[IDX_W-1:0];
          end
        end
      end
      S_SU_CHK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_dec[IDX_W-1:0];
        if (rm_q || rd_gt) begin
          mem_wdata_o = mem_rdata_i;
          ptr_d       = ptr_inc;
        end else begin
          done_d          = 1'b1;
          res_d.served_id = id_q;
        end
      end
      S_P_CHK: begin
        mem_raddr_o = ptr_inc[IDX_W-1:0];
        if (id_match) begin
          cred_d = rd_inc;
          if (ptr_q != '0 && prev_q < rd_inc) begin
            tpos_d      = ptr_q[IDX_W-1:0];
            ptr_d       = '0;
            mem_raddr_o = '0;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = ptr_q[IDX_W-1:0];
            mem_wdata_o = {id_q, rd_inc};
            done_d      = 1'b1;
          end
        end else begin
          prev_d = rd_cred;
          ptr_d  = ptr_inc;
          if (ptr_inc == occ_q) begin
            done_d = 1'b1;
            if (full) begin
              res_d.status = STAT_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = occ_q[IDX_W-1:0];
              mem_wdata_o = {id_q, CREDIT_BITS'(1)};
              occ_d       = occ_q + 1'b1;
            end
          end
        end
      end
      S_I_CHK: begin
        if (rd_le) begin
          lo_d  = ptr_q[IDX_W-1:0];
          ptr_d = CNT_W'(tpos_q) - 1'b1;
        end else begin
          ptr_d       = ptr_inc;
          mem_raddr_o = ptr_inc[IDX_W-1:0];
        end
      end
      S_SD_RD: begin
        mem_raddr_o = ptr_q[IDX_W-1:0];
      end
      S_SD_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_inc[IDX_W-1:0];
        mem_wdata_o = mem_rdata_i;
        if (ptr_q[IDX_W-1:0] != lo_q) begin
          ptr_d = ptr_dec;
        end
      end
      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lo_q;
        done_d      = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    ptr_q  <= ptr_d;
    lo_q   <= lo_d;
    tpos_q <= tpos_d;
    id_q   <= id_d;
    cred_q <= cred_d;
    prev_q <= prev_d;
    rm_q   <= rm_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: src/credit_sorted_worker_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit-sorted worker scheduler
// Keeps a list of worker entries (an add goes to the front, consume and
// produce reorder by credit) and serves add, consume and produce commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result is on the
// result ports for exactly one cycle with done_o high, in the cycle after the
// last cycle of the item, and the receiver cannot stall it; busy is low again
// in that same cycle. The list lives in a memory with one write port and one
// registered read port. The sequencer searches it one entry per cycle and
// moves an entry with a read state and a write state. An unused command, an
// add to a full list, a consume from an empty list and an add or produce
// into an empty list finish in the idle state.
module credit_sorted_worker_scheduler_top #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned CREDIT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [csws_pkg::CMD_W-1:0]    cmd_i,
  input  logic [csws_pkg::ID_W-1:0]     worker_id_i,
  input  logic                          cfg_we_i,
  input  logic [csws_pkg::INIT_W-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output logic [csws_pkg::ID_W-1:0]     served_id_o,
  output logic [csws_pkg::STAT_W-1:0]   status_o,
  output logic                          wake_o
);

  import csws_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned ENT_W = ID_W + CREDIT_BITS;

  logic [INIT_W-1:0] init_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;
  res_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= INIT_W'(8);
    end else if (cfg_we_i) begin
      init_q <= cfg_wdata_i;
    end
  end

  csws_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  csws_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CREDIT_BITS (CREDIT_BITS),
    .IDX_W       (IDX_W),
    .ENT_W       (ENT_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .cmd_i         (cmd_i),
    .worker_id_i   (worker_id_i),
    .init_credit_i (init_q),
    .busy_o        (busy),
    .done_o        (done_o),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  assign served_id_o = res.served_id;
  assign status_o    = res.status;
  assign wake_o      = res.wake;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the credit-sorted worker scheduler
// Drives add, consume, produce and unused commands through the start/busy
// handshake and checks every result against a list tracker that mirrors the
// ordered worker list. A directed part covers empty and full lists,
// duplicate ids, zero and unit initial credit and reordering. Random phases
// under several initial credit settings follow, and a short run of produces
// on the front worker ends the test.
// ----------------------------------------------------------------------------
module tb;
  import csws_pkg::*;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CRED_W = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class credit_list_tracker;
    bit [ID_W-1:0]   ids[DEPTH];
    bit [CRED_W-1:0] credits[DEPTH];
    int unsigned     count;
    bit [INIT_W-1:0] initial_credit;
    res_t            outcome_q[$];
    int unsigned     mismatches;

    function new();
      count = 0;
      initial_credit = 8'd8;
      mismatches = 0;
    endfunction

    function void pull_entry(int unsigned pos);
      for (int unsigned k = pos; k + 1 < count; k++) begin
        ids[k] = ids[k+1];
        credits[k] = credits[k+1];
      end
      count--;
    endfunction

    function void place_entry(int unsigned pos, bit [ID_W-1:0] id, bit [CRED_W-1:0] credit);
      for (int unsigned k = count; k > pos; k--) begin
        ids[k] = ids[k-1];
        credits[k] = credits[k-1];
      end
      ids[pos] = id;
      credits[pos] = credit;
      count++;
    endfunction

    function void apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
      res_t            r;
      int unsigned     j;
      bit [ID_W-1:0]   fid;
      bit [CRED_W-1:0] c;
      r = '0;
      case (cmd)
        CMD_ADD: begin
          if (count >= DEPTH) r.status = STAT_FULL;
          else place_entry(0, id, CRED_W'(initial_credit));
        end
        CMD_CONSUME: begin
          if (count == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            fid = ids[0];
            c = credits[0];
            r.served_id = fid;
            if (c <= 1) begin
              pull_entry(0);
            end else begin
              c = c - 1'b1;
              j = 1;
              while (j < count && credits[j] > c) j++;
              pull_entry(0);
              place_entry(j - 1, fid, c);
            end
          end
        end
        CMD_PRODUCE: begin
          if (count == 0) begin
            place_entry(0, id, CRED_W'(1));
            r.wake = 1'b1;
          end else begin
            j = 0;
            while (j < count && ids[j] != id) j++;
            if (j == count) begin
              if (count >= DEPTH) r.status = STAT_FULL;
              else place_entry(count, id, CRED_W'(1));
            end else begin
              c = credits[j];
              if (c != '1) c = c + 1'b1;
              credits[j] = c;
              if (j > 0 && credits[j-1] < c) begin
                pull_entry(j);
                j = 0;
                while (j < count && credits[j] > c) j++;
                place_entry(j, id, c);
              end
            end
          end
        end
        default: ;
      endcase
      outcome_q.push_back(r);
    endfunction

    function void note_error(string what, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void check_outcome(logic [ID_W-1:0] served, logic [STAT_W-1:0] status,
                                logic wake);
      res_t exp;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t ns: result with no item outstanding (served_id %0h status %0h)",
                   $time, served, status);
        return;
      end
      exp = outcome_q.pop_front();
      if (served !== exp.served_id) note_error("served_id", exp.served_id, served);
      if (status !== exp.status) note_error("status", ID_W'(exp.status), ID_W'(status));
      if (wake !== exp.wake) note_error("wake", ID_W'(exp.wake), ID_W'(wake));
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i       = '0;
  logic [ID_W-1:0]     worker_id_i = '0;
  logic                cfg_we_i    = 1'b0;
  logic [INIT_W-1:0]   cfg_wdata_i = '0;
  logic                done_o;
  logic [ID_W-1:0]     served_id_o;
  logic [STAT_W-1:0]   status_o;
  logic                wake_o;

  credit_list_tracker tracker = new();

  credit_sorted_worker_scheduler_top #(
    .MAX_ENTRIES(DEPTH),
    .CREDIT_BITS(CRED_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .worker_id_i(worker_id_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .served_id_o(served_id_o),
    .status_o   (status_o),
    .wake_o     (wake_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_outcome(served_id_o, status_o, wake_o);
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input int unsigned gap);
    start <= 1'b1;
    cmd_i <= cmd;
    worker_id_i <= id;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.apply_command(cmd, id);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    for (int n = 0; n < 20000 && tracker.pending() != 0; n++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_initial_credit(input logic [INIT_W-1:0] value);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.initial_credit = value;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      mode;
    int unsigned      roll;
    bit               quiet;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(8, 40);
      if (burst > n_items - sent) burst = n_items - sent;
      mode = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) cmd = CMD_UNUSED;
        else if (mode == 0) cmd = roll < 35 ? CMD_ADD : (roll < 68 ? CMD_CONSUME : CMD_PRODUCE);
        else if (mode == 1) cmd = roll < 45 ? CMD_ADD : (roll < 60 ? CMD_CONSUME : CMD_PRODUCE);
        else cmd = roll < 12 ? CMD_ADD : (roll < 80 ? CMD_CONSUME : CMD_PRODUCE);
        if ($urandom_range(0, 3) == 0) id = ID_W'($urandom_range(0, 255));
        else id = ID_W'($urandom_range(0, 19));
        send_item(cmd, id, quiet ? 0 : pick_gap());
        sent++;
      end
    end
  endtask

  initial begin
    logic [ID_W-1:0] sat_id;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_CONSUME, 8'h00, 0);
    send_item(CMD_UNUSED, 8'h00, 1);
    send_item(CMD_PRODUCE, 8'hFF, 0);
    send_item(CMD_PRODUCE, 8'hFF, 2);
    send_item(CMD_ADD, 8'h00, 0);
    send_item(CMD_PRODUCE, 8'h10, 0);
    send_item(CMD_PRODUCE, 8'h10, 0);
    send_item(CMD_PRODUCE, 8'h10, 3);
    send_item(CMD_ADD, 8'h00, 0);
    send_item(CMD_PRODUCE, 8'h00, 0);
    send_item(CMD_CONSUME, 8'hFF, 1);
    send_item(CMD_CONSUME, 8'h00, 0);
    send_item(CMD_UNUSED, 8'hFF, 0);
    send_item(CMD_CONSUME, 8'hA5, 0);

    set_initial_credit(8'd0);
    send_item(CMD_ADD, 8'h33, 0);
    send_item(CMD_CONSUME, 8'h00, 0);
    set_initial_credit(8'd1);
    send_item(CMD_ADD, 8'h44, 0);
    send_item(CMD_CONSUME, 8'h00, 0);

    set_initial_credit(8'd255);
    while (tracker.count < DEPTH) send_item(CMD_ADD, ID_W'(8'h80 + tracker.count), 0);
    send_item(CMD_ADD, 8'h7E, 0);
    send_item(CMD_PRODUCE, 8'hEE, 0);
    send_item(CMD_PRODUCE, 8'h00, 0);

    set_initial_credit(8'd1);
    run_random(280);
    set_initial_credit(8'd255);
    run_random(280);
    set_initial_credit(INIT_W'($urandom_range(2, 254)));
    run_random(280);
    set_initial_credit(8'd2);
    run_random(280);
    set_initial_credit(8'd8);
    run_random(280);

    // Keep producing on the front worker.
    settle();
    sat_id = tracker.count > 0 ? tracker.ids[0] : 8'hC3;
    repeat (24) send_item(CMD_PRODUCE, sat_id, 0);
    send_item(CMD_CONSUME, 8'h00, 0);
    send_item(CMD_PRODUCE, sat_id, 0);
    send_item(CMD_PRODUCE, sat_id, 0);

    settle();
    tracker.mismatches += tracker.pending();
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
src/csws_pkg.sv
src/csws_mem.sv
src/csws_seq.sv
src/credit_sorted_worker_scheduler_top.sv
tb/tb.sv
